>>> rtl/rsw_pkg.sv
// Package for the RIFF subchunk walker: payload and event types, codes and constants.
// Used by every module of the block; depends on nothing else.
package rsw_pkg;

  // Little-endian packed four-character codes of the container ids.
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_LIST = 32'h5453_494C;

  // Header geometry and counter widths.
  localparam int unsigned HDR_LEN   = 8;
  localparam int unsigned FIRST_HDR = 12;
  localparam int unsigned POS_W     = 34;
  localparam int unsigned NHP_W     = 35;
  localparam int unsigned LIMIT_W   = 33;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Default depth of the event queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ID    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_INDEX = 8'd1;

  // Result kinds.
  localparam logic KIND_SUB     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result request.
  typedef struct packed {
    logic        result_kind;
    logic        is_container;
    logic [31:0] form_type;
    logic [31:0] sub_id;
    logic [31:0] sub_size;
    logic [32:0] sub_offset;
    logic [31:0] sub_index_or_count;
    logic        id_match;
    logic        index_match;
    logic        last;
  } res_t;

  // Event handed from the front to the back: a subchunk header, a summary, or both.
  typedef struct packed {
    logic        has_sub;
    logic        has_sum;
    logic        is_container;
    logic [31:0] form_type;
    logic [31:0] sub_id;
    logic [31:0] sub_size;
    logic [32:0] sub_offset;
    logic [31:0] sub_index;
    logic [31:0] count;
  } ev_t;

  // Back end output phase.
  typedef enum logic {
    BK_SUB,
    BK_SUM
  } back_state_t;

endpackage

>>> rtl/rsw_front.sv
// Front end of the RIFF subchunk walker: accepts bytes, assembles headers, makes events.
// Depends on rsw_pkg.
module rsw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsw_pkg::in_t  in_data,
  input  logic          full,
  output logic          push,
  output rsw_pkg::ev_t  ev
);

  logic [rsw_pkg::POS_W-1:0]   pos, pos_next;
  logic [31:0]                 outer_id, outer_id_next;
  logic [31:0]                 outer_size, outer_size_next;
  logic [31:0]                 outer_form, outer_form_next;
  logic [rsw_pkg::LIMIT_W-1:0] limit, limit_next;
  logic [63:0]                 hdr_shift, hdr_shift_next;
  logic [3:0]                  hdr_cnt, hdr_cnt_next;
  logic [rsw_pkg::NHP_W-1:0]   nhp, nhp_next;
  logic [31:0]                 sub_count, sub_count_next;
  logic                        walk_done, walk_done_next;

  logic                        accept;
  logic                        container;
  logic                        emit_sub;
  logic [7:0]                  b;
  logic [3:0]                  cnt_inc;
  logic [rsw_pkg::LIMIT_W-1:0] step;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  // Per-byte walk step.
  always_comb begin
    outer_id_next   = outer_id;
    outer_size_next = outer_size;
    outer_form_next = outer_form;
    limit_next      = limit;
    hdr_shift_next  = hdr_shift;
    hdr_cnt_next    = hdr_cnt;
    nhp_next        = nhp;
    sub_count_next  = sub_count;
    walk_done_next  = walk_done;
    emit_sub        = 1'b0;
    cnt_inc         = hdr_cnt + 4'd1;
    step            = {1'b0, hdr_shift_next[63:32]};

    // Outer id, size and form type over the first twelve bytes.
    if (pos < rsw_pkg::POS_W'(rsw_pkg::FIRST_HDR)) begin
      case (pos[3:2])
        2'd0: outer_id_next[{pos[1:0], 3'b000} +: 8] = b;
        2'd1: begin
          outer_size_next[{pos[1:0], 3'b000} +: 8] = b;
          limit_next = {1'b0, outer_size_next} + rsw_pkg::LIMIT_W'(rsw_pkg::HDR_LEN);
        end
        2'd2: outer_form_next[{pos[1:0], 3'b000} +: 8] = b;
        default: ;
      endcase
    end
    container = (outer_id_next == rsw_pkg::ID_RIFF) || (outer_id_next == rsw_pkg::ID_LIST);

    // Subchunk header walk inside a container.
    if (pos >= rsw_pkg::POS_W'(rsw_pkg::FIRST_HDR) && !walk_done && container) begin
      if (hdr_cnt == 4'd0) begin
        if ({1'b0, pos} == nhp) begin
          if (pos < {1'b0, limit}) begin
            hdr_shift_next = {56'd0, b};
            hdr_cnt_next   = 4'd1;
          end else begin
            walk_done_next = 1'b1;
          end
        end
      end else begin
        hdr_shift_next[{hdr_cnt[2:0], 3'b000} +: 8] = b;
        hdr_cnt_next = cnt_inc;
        if (cnt_inc == 4'd4 && hdr_shift_next[31:0] == 32'd0) begin
          walk_done_next = 1'b1;
          hdr_cnt_next   = 4'd0;
        end else if (cnt_inc >= 4'(rsw_pkg::HDR_LEN)) begin
          emit_sub       = 1'b1;
          step           = {1'b0, hdr_shift_next[63:32]}
                           + rsw_pkg::LIMIT_W'(rsw_pkg::HDR_LEN)
                           + {32'd0, hdr_shift_next[32]};
          nhp_next       = nhp + {2'b00, step};
          sub_count_next = sub_count + 32'd1;
          hdr_cnt_next   = 4'd0;
        end
      end
    end

    pos_next = (pos != rsw_pkg::POS_MAX) ? pos + rsw_pkg::POS_W'(1) : pos;

    // Event record for the back end.
    ev.has_sub      = emit_sub;
    ev.has_sum      = in_data.last_byte;
    ev.is_container = container;
    ev.form_type    = container ? outer_form_next : 32'd0;
    ev.sub_id       = hdr_shift_next[31:0];
    ev.sub_size     = hdr_shift_next[63:32];
    ev.sub_offset   = nhp[32:0];
    ev.sub_index    = sub_count;
    ev.count        = sub_count_next;
    push            = accept && (emit_sub || in_data.last_byte);
  end

  // Walk state; the last byte restarts the walk.
  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      pos        <= '0;
      outer_id   <= '0;
      outer_size <= '0;
      outer_form <= '0;
      limit      <= rsw_pkg::LIMIT_W'(rsw_pkg::HDR_LEN);
      hdr_shift  <= '0;
      hdr_cnt    <= '0;
      nhp        <= rsw_pkg::NHP_W'(rsw_pkg::FIRST_HDR);
      sub_count  <= '0;
      walk_done  <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      outer_id   <= outer_id_next;
      outer_size <= outer_size_next;
      outer_form <= outer_form_next;
      limit      <= limit_next;
      hdr_shift  <= emit_sub ? 64'd0 : hdr_shift_next;
      hdr_cnt    <= hdr_cnt_next;
      nhp        <= nhp_next;
      sub_count  <= sub_count_next;
      walk_done  <= walk_done_next;
    end
  end

endmodule

>>> rtl/rsw_queue.sv
// Event queue between the front and back ends of the RIFF subchunk walker.
// Depends on rsw_pkg for the event type.
module rsw_queue #(
  parameter int unsigned DEPTH = rsw_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rsw_pkg::ev_t push_data,
  input  logic         pop,
  output rsw_pkg::ev_t head,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rsw_pkg::ev_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/rsw_back.sv
// Back end of the RIFF subchunk walker: turns events into result requests.
// Depends on rsw_pkg.
module rsw_back (
  input  logic          clk,
  input  logic          rst,
  input  rsw_pkg::ev_t  head,
  input  logic          empty,
  output logic          pop,
  input  logic [31:0]   match_id,
  input  logic [31:0]   match_index,
  output logic          out_valid,
  input  logic          out_ready,
  output rsw_pkg::res_t out_data
);

  rsw_pkg::back_state_t state, state_next;
  rsw_pkg::res_t        res;
  logic                 load;

  // Pick the next result from the head event and decide when it is used up.
  always_comb begin
    load       = (!out_valid || out_ready) && !empty;
    state_next = state;
    pop        = 1'b0;

    res.is_container = head.is_container;
    res.form_type    = head.form_type;

    if (state == rsw_pkg::BK_SUB && head.has_sub) begin
      res.result_kind        = rsw_pkg::KIND_SUB;
      res.sub_id             = head.sub_id;
      res.sub_size           = head.sub_size;
      res.sub_offset         = head.sub_offset;
      res.sub_index_or_count = head.sub_index;
      res.id_match           = (head.sub_id == match_id);
      res.index_match        = (head.sub_index == match_index);
      res.last               = !head.has_sum;
      if (load) begin
        if (head.has_sum) begin
          state_next = rsw_pkg::BK_SUM;
        end else begin
          pop = 1'b1;
        end
      end
    end else begin
      res.result_kind        = rsw_pkg::KIND_SUMMARY;
      res.sub_id             = '0;
      res.sub_size           = '0;
      res.sub_offset         = '0;
      res.sub_index_or_count = head.count;
      res.id_match           = 1'b0;
      res.index_match        = 1'b0;
      res.last               = 1'b1;
      if (load) begin
        pop        = 1'b1;
        state_next = rsw_pkg::BK_SUB;
      end
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsw_pkg::BK_SUB;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

>>> rtl/riff_subchunk_walker.sv
// Top level of the RIFF subchunk walker: configuration registers, front, queue and back.
// Depends on rsw_pkg, rsw_front, rsw_queue and rsw_back.
//
// Usage: bytes of one outer chunk arrive one per request on in_valid/in_ready;
// in_data.last_byte marks the final byte, after which the walk restarts.
// Every complete subchunk header of a RIFF or LIST chunk yields one result
// request, and the last byte yields a summary with the subchunk count, after
// the header result when both fall on the same byte. Results leave on out_valid/out_ready.
// match_id and match_index are set through cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The front classifies
// each byte in the cycle it is taken and writes any event into a queue of
// QUEUE_DEPTH entries; the back end sends one result at a time, both in turn
// for a byte that gives two results.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready drops only when the queue is full.
// Reset clears the walk state, the queue, out_valid and both
// configuration registers; no clearing pass is needed.
module riff_subchunk_walker #(
  parameter int unsigned QUEUE_DEPTH = rsw_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsw_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsw_pkg::res_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic [31:0]  match_id;
  logic [31:0]  match_index;
  logic         q_push, q_pop, q_full, q_empty;
  rsw_pkg::ev_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_id    <= '0;
      match_index <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsw_pkg::REG_MATCH_ID:    match_id    <= cfg_data;
        rsw_pkg::REG_MATCH_INDEX: match_index <= cfg_data;
        default: ;
      endcase
    end
  end

  rsw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (q_full),
    .push     (q_push),
    .ev       (q_in)
  );

  rsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rsw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .match_id    (match_id),
    .match_index (match_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
